FILE: hdl/dmx_phase_angle_dimmer_8ch_top_macros.svh
// assertion macros for the dmx dimmer block
// expects signals named clk and rst in the scope of use
`ifndef DMX_PHASE_ANGLE_DIMMER_8CH_TOP_MACROS_SVH
`define DMX_PHASE_ANGLE_DIMMER_8CH_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define DMX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DMX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dmx_pad_pkg.sv
// shared types and constants for the dmx phase-angle dimmer
// no dependencies
package dmx_pad_pkg;

  // default sizing
  localparam int CHANNELS_DEF       = 8;
  localparam int PHASE_STEPS_DEF    = 240;
  localparam int UNIVERSE_SLOTS_DEF = 513;

  // fixed widths
  localparam int SLOT_W    = 10;
  localparam int START_W   = 9;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // reset values of the registers
  localparam logic [START_W-1:0]   START_ADDRESS_RST = 9'd1;
  localparam logic                 DIMMER_MODE_RST   = 1'b1;
  localparam logic [TIMEOUT_W-1:0] LOST_TIMEOUT_RST  = 16'd8000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMMER_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT  = 2'd2;

  // item kinds
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_SYNC = 2'd2;

  // switch-mode threshold and full level
  localparam logic [7:0] SWITCH_THRESHOLD = 8'd128;
  localparam logic [7:0] LEVEL_FULL       = 8'd255;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       framing_error;
  } in_item_t;

  typedef struct packed {
    logic [7:0] channel_bits;
    logic [7:0] phase;
    logic       signal_lost;
  } out_item_t;

endpackage

FILE: hdl/dmx_phase_angle_dimmer_8ch_top.sv
// Eight-channel DMX512 receiver with phase-angle dimmer outputs. One transaction is
// taken every clock cycle while item_stall is low: a received byte, a timer tick or
// a zero-cross sync is decoded and applied to the frame state, the slot window and
// the phase counter in the cycle it is accepted, and a tick's result is registered,
// in the skid register if the output stalls. Only ticks produce a result. Results
// pass through an output register and a skid register, so item_stall rises only when
// both hold a result that the far side has not yet taken. Register writes are taken
// every cycle (cfg_ready is always high) and must only be issued while the block is idle.
// depends on dmx_pad_pkg, dmx_pad_level, dmx_pad_skid and the assertion macros
`include "dmx_phase_angle_dimmer_8ch_top_macros.svh"

module dmx_phase_angle_dimmer_8ch_top #(
  parameter int CHANNELS       = dmx_pad_pkg::CHANNELS_DEF,
  parameter int PHASE_STEPS    = dmx_pad_pkg::PHASE_STEPS_DEF,
  parameter int UNIVERSE_SLOTS = dmx_pad_pkg::UNIVERSE_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  dmx_pad_pkg::in_item_t              item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output dmx_pad_pkg::out_item_t             result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dmx_pad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmx_pad_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import dmx_pad_pkg::*;

  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_OUT_W = (CHANNELS > 8) ? CHANNELS : 8;
  localparam logic [SLOT_W-1:0] START_HI   = SLOT_W'(UNIVERSE_SLOTS - CHANNELS);
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(UNIVERSE_SLOTS);
  localparam logic [8:0]        PHASE_MAX  = 9'(PHASE_STEPS);

  // configuration registers
  logic [START_W-1:0]   start_address;
  logic                 dimmer_mode;
  logic [TIMEOUT_W-1:0] lost_timeout;

  // receiver and dimmer state
  logic [SLOT_W-1:0]        slot_count, slot_count_next;
  logic                     frame_valid, frame_valid_next;
  logic [TIMEOUT_W-1:0]     lost_count, lost_count_next;
  logic [7:0]               phase_step, phase_step_next;
  logic [CHANNELS-1:0][7:0] window, window_next;

  logic                accept;
  logic                push;
  logic [SLOT_W-1:0]   win_start;
  logic [SLOT_W:0]     win_end;
  logic                in_win;
  logic [SLOT_W-1:0]   win_offset;
  logic [IDX_W-1:0]    win_idx;
  logic [8:0]          phase_inc;
  logic [CHANNELS-1:0] lvl_bits;
  logic [CH_OUT_W-1:0] bits_wide;
  out_item_t           new_result;
  logic                buf_full;

  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !item_stall;
  assign item_stall = buf_full;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= START_ADDRESS_RST;
      dimmer_mode   <= DIMMER_MODE_RST;
      lost_timeout  <= LOST_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ADDRESS: start_address <= cfg_data[START_W-1:0];
        REG_DIMMER_MODE:   dimmer_mode   <= cfg_data[0];
        REG_LOST_TIMEOUT:  lost_timeout  <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // window start clamped into the universe
  always_comb begin
    win_start = {1'b0, start_address};
    if (win_start == '0) begin
      win_start = SLOT_W'(1);
    end
    if (win_start > START_HI) begin
      win_start = START_HI;
    end
  end

  assign win_end    = {1'b0, win_start} + (SLOT_W+1)'(CHANNELS);
  assign in_win     = (slot_count >= win_start) && ({1'b0, slot_count} < win_end);
  assign win_offset = slot_count - win_start;
  assign win_idx    = win_offset[IDX_W-1:0];
  assign phase_inc  = {1'b0, phase_step} + 9'd1;

  // next state for one accepted transaction
  always_comb begin
    slot_count_next  = slot_count;
    frame_valid_next = frame_valid;
    lost_count_next  = lost_count;
    phase_step_next  = phase_step;
    window_next      = window;
    if (accept) begin
      case (item.action)
        ACT_BYTE: begin
          if (item.framing_error) begin
            if (slot_count > SLOT_W'(1)) begin
              lost_count_next = '0;
            end
            frame_valid_next = (item.rx_byte == 8'd0);
            slot_count_next  = (item.rx_byte == 8'd0) ? SLOT_W'(1) : '0;
          end else if (frame_valid && (slot_count < SLOT_LIMIT)) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (in_win && (win_idx == IDX_W'(i))) begin
                window_next[i] = item.rx_byte;
              end
            end
            slot_count_next = slot_count + SLOT_W'(1);
          end
        end
        ACT_TICK: begin
          phase_step_next = (phase_inc > PHASE_MAX) ? 8'd0 : phase_inc[7:0];
          if (lost_count < lost_timeout) begin
            lost_count_next = lost_count + TIMEOUT_W'(1);
          end
        end
        ACT_SYNC: phase_step_next = 8'd0;
        default: ;
      endcase
      // signal lost clears the kept values
      if (lost_count_next >= lost_timeout) begin
        window_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= '0;
      frame_valid <= 1'b0;
      lost_count  <= LOST_TIMEOUT_RST;
      phase_step  <= 8'd0;
      window      <= '0;
    end else begin
      slot_count  <= slot_count_next;
      frame_valid <= frame_valid_next;
      lost_count  <= lost_count_next;
      phase_step  <= phase_step_next;
      window      <= window_next;
    end
  end

  // channel compares against the phase after this tick
  dmx_pad_level #(
    .CHANNELS (CHANNELS)
  ) u_level (
    .window      (window),
    .phase       (phase_step_next),
    .dimmer_mode (dimmer_mode),
    .bits        (lvl_bits)
  );

  assign bits_wide               = CH_OUT_W'(lvl_bits);
  assign new_result.channel_bits = bits_wide[7:0];
  assign new_result.phase        = phase_step_next;
  assign new_result.signal_lost  = (lost_count_next >= lost_timeout);
  assign push                    = accept && (item.action == ACT_TICK);

  // result buffering
  dmx_pad_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (new_result),
    .full      (buf_full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result)
  );

  `DMX_ASSERT_NOW(a_skid_behind_out, item_stall, result_valid, "skid full with output empty")
  `DMX_ASSERT_NOW(a_phase_range, 1'b1, phase_step <= 8'(PHASE_STEPS), "phase out of range")
  `DMX_ASSERT_NEXT(a_sync_clears_phase, accept && (item.action == ACT_SYNC),
    phase_step == 8'd0, "sync did not reset phase")
  `DMX_ASSERT_NEXT(a_tick_gives_result, push, result_valid, "tick produced no result")

endmodule

FILE: hdl/dmx_pad_level.sv
// per-channel level derivation and phase compare
// depends on dmx_pad_pkg
module dmx_pad_level #(
  parameter int CHANNELS = dmx_pad_pkg::CHANNELS_DEF
) (
  input  logic [CHANNELS-1:0][7:0] window,
  input  logic [7:0]               phase,
  input  logic                     dimmer_mode,
  output logic [CHANNELS-1:0]      bits
);
  import dmx_pad_pkg::*;

  logic [CHANNELS-1:0][7:0] level;

  // level per channel, then on while phase exceeds it
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (dimmer_mode) begin
        level[i] = LEVEL_FULL - window[i];
      end else if (window[i] > SWITCH_THRESHOLD) begin
        level[i] = 8'd0;
      end else begin
        level[i] = LEVEL_FULL;
      end
      bits[i] = (phase > level[i]);
    end
  end

endmodule

FILE: hdl/dmx_pad_skid.sv
// two-entry result buffer: output register plus skid register
// depends on dmx_pad_pkg
module dmx_pad_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dmx_pad_pkg::out_item_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dmx_pad_pkg::out_item_t out_data
);
  import dmx_pad_pkg::*;

  logic      skid_valid;
  out_item_t skid_data;
  logic      out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  // control: output register fed from skid first, new transaction after
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: bench/dmx_phase_angle_dimmer_8ch_checker.sv
`timescale 1ns / 100ps
// checker for the dmx phase-angle dimmer: watches all three channels, keeps its own
// copy of the frame, window, phase and lost-signal state and compares every tick result
// depends on dmx_pad_pkg
module dmx_phase_angle_dimmer_8ch_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  dmx_pad_pkg::in_item_t             item,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  dmx_pad_pkg::out_item_t            result,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [dmx_pad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmx_pad_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                results_seen
);
  import dmx_pad_pkg::*;

  // highest first slot that still leaves room for all channels
  localparam int WINDOW_LAST = UNIVERSE_SLOTS_DEF - CHANNELS_DEF;

  // register copies
  logic [START_W-1:0]   start_reg;
  logic                 dimmer_reg;
  logic [TIMEOUT_W-1:0] timeout_reg;

  // frame and dimmer state
  logic [SLOT_W-1:0]    slot_cnt;
  logic                 in_frame;
  logic [TIMEOUT_W-1:0] lost_cnt;
  logic [7:0]           phase_cnt;
  logic [7:0]           win_level [CHANNELS_DEF];

  // tick results still owed by the block, oldest first
  out_item_t tick_results_q [$];
  int        errs = 0;
  int        nres = 0;

  always @(posedge clk) begin
    int          i;
    logic [9:0]  first;
    logic [7:0]  lvl;
    logic [7:0]  bits;
    out_item_t   want;
    if (rst) begin
      start_reg   = START_ADDRESS_RST;
      dimmer_reg  = DIMMER_MODE_RST;
      timeout_reg = LOST_TIMEOUT_RST;
      slot_cnt    = '0;
      in_frame    = 1'b0;
      lost_cnt    = LOST_TIMEOUT_RST;
      phase_cnt   = '0;
      for (i = 0; i < CHANNELS_DEF; i++) win_level[i] = '0;
      tick_results_q.delete();
    end else begin
      // result transaction against the oldest outstanding tick
      if (result_valid && !result_stall) begin
        nres++;
        if (tick_results_q.size() == 0) begin
          errs++;
          $error("result transaction with no tick outstanding: %p", result);
        end else begin
          want = tick_results_q.pop_front();
          if (result.channel_bits !== want.channel_bits) begin
            errs++;
            $error("channel_bits expected %02h actual %02h", want.channel_bits,
                   result.channel_bits);
          end
          if (result.phase !== want.phase) begin
            errs++;
            $error("phase expected %0d actual %0d", want.phase, result.phase);
          end
          if (result.signal_lost !== want.signal_lost) begin
            errs++;
            $error("signal_lost expected %0b actual %0b", want.signal_lost,
                   result.signal_lost);
          end
        end
      end

      // register writes, masked to the register width
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_ADDRESS: start_reg   = cfg_data[START_W-1:0];
          REG_DIMMER_MODE:   dimmer_reg  = cfg_data[0];
          REG_LOST_TIMEOUT:  timeout_reg = cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end

      // input transaction
      if (item_valid && !item_stall) begin
        case (item.action)
          ACT_BYTE: begin
            if (item.framing_error) begin
              // break: a frame with data behind it counts as a sign of life
              if (slot_cnt > 1) lost_cnt = '0;
              if (item.rx_byte == 8'd0) begin
                in_frame = 1'b1;
                slot_cnt = 10'd1;
              end else begin
                in_frame = 1'b0;
                slot_cnt = '0;
              end
            end else if (in_frame && slot_cnt < UNIVERSE_SLOTS_DEF) begin
              // clamp the window start to the universe
              if (start_reg == '0) first = 10'd1;
              else if (start_reg > WINDOW_LAST) first = 10'(WINDOW_LAST);
              else first = {1'b0, start_reg};
              if (slot_cnt >= first && slot_cnt < first + 10'(CHANNELS_DEF))
                win_level[3'(slot_cnt - first)] = item.rx_byte;
              slot_cnt = slot_cnt + 10'd1;
            end
          end
          ACT_TICK: begin
            phase_cnt = (phase_cnt >= 8'(PHASE_STEPS_DEF)) ? 8'd0 : phase_cnt + 8'd1;
            for (i = 0; i < CHANNELS_DEF; i++) begin
              if (dimmer_reg) lvl = LEVEL_FULL - win_level[i];
              else lvl = (win_level[i] > SWITCH_THRESHOLD) ? 8'd0 : LEVEL_FULL;
              bits[i] = phase_cnt > lvl;
            end
            if (lost_cnt < timeout_reg) lost_cnt = lost_cnt + 16'd1;
            want.channel_bits = bits;
            want.phase        = phase_cnt;
            want.signal_lost  = (lost_cnt >= timeout_reg);
            tick_results_q.push_back(want);
          end
          ACT_SYNC: phase_cnt = '0;
          default: ;
        endcase
        // lost signal wipes the kept levels after every transaction
        if (lost_cnt >= timeout_reg)
          for (i = 0; i < CHANNELS_DEF; i++) win_level[i] = '0;
      end
    end
    fail_count   <= errs;
    pending      <= tick_results_q.size();
    results_seen <= nres;
  end

endmodule

FILE: bench/dmx_phase_angle_dimmer_8ch_top_tb.sv
`timescale 1ns / 100ps
// testbench top for the dmx phase-angle dimmer: clock, reset, stimulus, idling and verdict
// depends on dmx_pad_pkg, the dimmer top level and dmx_phase_angle_dimmer_8ch_checker
module dmx_phase_angle_dimmer_8ch_top_tb;
  import dmx_pad_pkg::*;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         HOLD_CYCLES    = 60;
  localparam int         SETTLE_CYCLES  = 4;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  in_item_t             item         = '0;
  logic                 result_valid;
  logic                 result_stall;
  out_item_t            result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_DAT_W-1:0] cfg_data     = '0;

  int fail_count;
  int pending;
  int results_seen;

  // idling percentages and the one-off receiver hold-off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;

  int items_sent = 0;
  int ticks_sent = 0;
  int win_first  = 1;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  dmx_phase_angle_dimmer_8ch_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dmx_phase_angle_dimmer_8ch_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  function automatic in_item_t mk_item(logic [1:0] act, logic [7:0] data, logic fe);
    in_item_t it;
    it.action        = act;
    it.rx_byte       = data;
    it.framing_error = fe;
    return it;
  endfunction

  // slot data, leaning now and then on the threshold and full-scale values
  function automatic logic [7:0] slot_byte();
    logic [7:0] edges [5] = '{8'd0, 8'd127, 8'd128, 8'd129, 8'd255};
    if ($urandom_range(99) < 15) return edges[$urandom_range(4)];
    return 8'($urandom);
  endfunction

  // one input transaction, with random idle cycles in front of it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item       = it;
    do @(posedge clk); while (!(item_valid && !item_stall));
    @(negedge clk);
    items_sent++;
    if (it.action == ACT_TICK) ticks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input int start, input int mode, input int timeout);
    write_reg(REG_START_ADDRESS, CFG_DAT_W'(start));
    write_reg(REG_DIMMER_MODE, CFG_DAT_W'(mode));
    write_reg(REG_LOST_TIMEOUT, CFG_DAT_W'(timeout));
    cfg_valid = 1'b0;
    win_first = (start == 0) ? 1 : (start > UNIVERSE_SLOTS_DEF - CHANNELS_DEF) ?
                UNIVERSE_SLOTS_DEF - CHANNELS_DEF : start;
  endtask

  // drain all outstanding ticks, then let the pipeline idle before returning
  task automatic settle();
    item_valid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // break with zero start code followed by a run of slot data, with stray breaks if noisy
  task automatic send_frame(input int n_slots, input bit noisy);
    send_item(mk_item(ACT_BYTE, 8'd0, 1'b1));
    repeat (n_slots) begin
      if (noisy && ($urandom_range(99) < 4))
        send_item(mk_item(ACT_BYTE, 8'($urandom_range(255, 1)), 1'b1));
      else
        send_item(mk_item(ACT_BYTE, slot_byte(), 1'b0));
    end
  endtask

  // mostly well-formed frames and tick runs, with syncs and noise mixed in
  task automatic random_traffic(input int n);
    int base;
    int kind;
    int len;
    base = items_sent;
    while (items_sent - base < n) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        len = $urandom_range((win_first < 24) ? win_first + 10 : 12, 0);
        send_frame(len, 1'b1);
      end else if (kind < 70) begin
        len = ($urandom_range(99) < 15) ? $urandom_range(50, 30) : $urandom_range(12, 1);
        repeat (len) send_item(mk_item(ACT_TICK, 8'($urandom), 1'($urandom)));
      end else if (kind < 78) begin
        send_item(mk_item(ACT_SYNC, 8'($urandom), 1'($urandom)));
      end else begin
        send_item(mk_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom)));
      end
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else begin
        result_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender idles lightly, receiver heavily
    send_idle_pct = 23;
    recv_idle_pct = 75;

    // directed: reset settings, a full window of edge values, sync, bad break, noise
    send_item(mk_item(ACT_TICK, 8'h00, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'h00, 1'b1));
    send_item(mk_item(ACT_BYTE, 8'hFF, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'h00, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'h80, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'h81, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'h7F, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'hF1, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'hFE, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'hAA, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'h00, 1'b1));
    repeat (3) send_item(mk_item(ACT_TICK, 8'hFF, 1'b1));
    send_item(mk_item(ACT_SYNC, 8'h00, 1'b0));
    send_item(mk_item(ACT_TICK, 8'h55, 1'b0));
    send_item(mk_item(ACT_BYTE, 8'h55, 1'b1));
    send_item(mk_item(ACT_BYTE, 8'h12, 1'b0));
    send_item(mk_item(ACT_UNUSED, 8'hFF, 1'b1));
    send_item(mk_item(ACT_TICK, 8'h00, 1'b1));
    settle();

    set_config(3, 1, 45);
    random_traffic(30);
    settle();

    // receiver idles lightly, sender heavily; switch mode, shortest timeouts
    send_idle_pct = 75;
    recv_idle_pct = 23;
    set_config(0, 0, 1);
    random_traffic(20);
    settle();
    set_config(17, 0, 0);
    random_traffic(12);
    settle();

    // no idling; a clean frame past the top of the universe and the long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(511, 1, 65535);
    send_frame(514, 1'b0);
    hold_req = 1'b1;
    repeat (12) send_item(mk_item(ACT_TICK, 8'h00, 1'b0));
    random_traffic(10);
    settle();
    set_config(5, 0, 40);
    random_traffic(15);
    settle();

    $display("covered %0d input transactions (%0d ticks), %0d results compared", items_sent,
             ticks_sent, results_seen);
    $display("start addresses 0, 3, 5, 17 and 511, both modes, timeouts 0 to 65535, "
             , "one frame run past the last slot");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/dmx_pad_pkg.sv
hdl/dmx_pad_level.sv
hdl/dmx_pad_skid.sv
hdl/dmx_phase_angle_dimmer_8ch_top.sv
bench/dmx_phase_angle_dimmer_8ch_checker.sv
bench/dmx_phase_angle_dimmer_8ch_top_tb.sv
